// ----- rtl/qmr_pkg.sv -----
package qmr_pkg;

  // fixed field widths of the payload
  localparam int unsigned DATA_W = 16;
  localparam int unsigned PROD_W = 2 * DATA_W;
  // four products plus the rounding constant need two guard bits
  localparam int unsigned ACC_W  = PROD_W + 2;

  // register stages inside one hamilton product unit
  localparam int unsigned HAM_DEPTH = 3;

  // operation codes
  localparam logic OP_MUL = 1'b0;
  localparam logic OP_ROT = 1'b1;

  // component indexes
  localparam logic [1:0] IDX_X = 2'd0;
  localparam logic [1:0] IDX_Y = 2'd1;
  localparam logic [1:0] IDX_Z = 2'd2;
  localparam logic [1:0] IDX_W = 2'd3;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
  } quat_t;

  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] p_x;
    logic signed [DATA_W-1:0] p_y;
    logic signed [DATA_W-1:0] p_z;
    logic signed [DATA_W-1:0] p_w;
    logic signed [DATA_W-1:0] s_x;
    logic signed [DATA_W-1:0] s_y;
    logic signed [DATA_W-1:0] s_z;
    logic signed [DATA_W-1:0] s_w;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] r_x;
    logic signed [DATA_W-1:0] r_y;
    logic signed [DATA_W-1:0] r_z;
    logic signed [DATA_W-1:0] r_w;
  } out_t;

  // hamilton product terms, four per result component in x, y, z, w order
  // term k multiplies p[P_SEL[k]] by s[S_SEL[k]], subtracted when TERM_NEG[k]
  localparam logic [1:0] P_SEL [16] = '{
    IDX_W, IDX_X, IDX_Y, IDX_Z,
    IDX_W, IDX_Y, IDX_Z, IDX_X,
    IDX_W, IDX_Z, IDX_X, IDX_Y,
    IDX_W, IDX_X, IDX_Y, IDX_Z
  };

  localparam logic [1:0] S_SEL [16] = '{
    IDX_X, IDX_W, IDX_Z, IDX_Y,
    IDX_Y, IDX_W, IDX_X, IDX_Z,
    IDX_Z, IDX_W, IDX_Y, IDX_X,
    IDX_W, IDX_X, IDX_Y, IDX_Z
  };

  localparam logic TERM_NEG [16] = '{
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b0, 1'b0, 1'b1,
    1'b0, 1'b1, 1'b1, 1'b1
  };

endpackage

// ----- rtl/qmr_hamilton.sv -----
module qmr_hamilton #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          conj_i,
  input  qmr_pkg::quat_t p_i,
  input  qmr_pkg::quat_t s_i,
  output logic          valid_o,
  output qmr_pkg::quat_t r_o
);

  localparam int unsigned DW = qmr_pkg::DATA_W;
  localparam int unsigned PW = qmr_pkg::PROD_W;
  localparam int unsigned AW = qmr_pkg::ACC_W;

  localparam logic signed [AW-1:0] HALF   = {{(AW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] SAT_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [AW-1:0] SAT_LO = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [DW-1:0] pa [4];
  logic signed [DW-1:0] sa [4];

  logic                 v1_q, v2_q, v3_q;
  logic                 conj1_q;
  logic signed [PW-1:0] prod_d [16];
  logic signed [PW-1:0] prod_q [16];
  logic signed [AW-1:0] acc_d [4];
  logic signed [AW-1:0] acc_q [4];
  logic signed [DW-1:0] res_d [4];
  logic signed [DW-1:0] res_q [4];

  // operands as indexable arrays
  assign pa[qmr_pkg::IDX_X] = p_i.x;
  assign pa[qmr_pkg::IDX_Y] = p_i.y;
  assign pa[qmr_pkg::IDX_Z] = p_i.z;
  assign pa[qmr_pkg::IDX_W] = p_i.w;
  assign sa[qmr_pkg::IDX_X] = s_i.x;
  assign sa[qmr_pkg::IDX_Y] = s_i.y;
  assign sa[qmr_pkg::IDX_Z] = s_i.z;
  assign sa[qmr_pkg::IDX_W] = s_i.w;

  // stage 1: sixteen partial products
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      prod_d[k] = PW'(pa[qmr_pkg::P_SEL[k]]) * PW'(sa[qmr_pkg::S_SEL[k]]);
    end
  end

  // stage 2: signed sums; conj flips every term that uses the s vector part
  always_comb begin
    logic signed [AW-1:0] term;
    logic                 neg;
    term = '0;
    neg  = 1'b0;
    for (int c = 0; c < 4; c++) begin
      acc_d[c] = '0;
      for (int j = 0; j < 4; j++) begin
        term = {{(AW-PW){prod_q[c*4+j][PW-1]}}, prod_q[c*4+j]};
        neg  = qmr_pkg::TERM_NEG[c*4+j] ^
               (conj1_q && (qmr_pkg::S_SEL[c*4+j] != qmr_pkg::IDX_W));
        if (neg) begin
          acc_d[c] = acc_d[c] - term;
        end else begin
          acc_d[c] = acc_d[c] + term;
        end
      end
    end
  end

  // stage 3: round half up and saturate
  always_comb begin
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] sh;
    rnd = '0;
    sh  = '0;
    for (int c = 0; c < 4; c++) begin
      rnd = acc_q[c] + HALF;
      sh  = rnd >>> FRAC_BITS;
      if (sh > SAT_HI) begin
        res_d[c] = SAT_HI[DW-1:0];
      end else if (sh < SAT_LO) begin
        res_d[c] = SAT_LO[DW-1:0];
      end else begin
        res_d[c] = sh[DW-1:0];
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // data stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      conj1_q <= conj_i;
      prod_q  <= prod_d;
      acc_q   <= acc_d;
      res_q   <= res_d;
    end
  end

  assign valid_o = v3_q;
  assign r_o.x   = res_q[qmr_pkg::IDX_X];
  assign r_o.y   = res_q[qmr_pkg::IDX_Y];
  assign r_o.z   = res_q[qmr_pkg::IDX_Z];
  assign r_o.w   = res_q[qmr_pkg::IDX_W];

endmodule

// ----- rtl/quaternion_multiply_rotate_core.sv -----
// channel | direction | handshake              | payload
// in      | input     | in_valid_i, in_stall_o  | in_data_i  (qmr_pkg::in_t)
// out     | output    | out_valid_o, out_stall_i | out_data_o (qmr_pkg::out_t)
//
// one transaction per cycle unless a valid result is stalled, through two chained
// three-stage hamilton product units (multiply, sum, round)
// multiply passes the first product down a delay line; rotate uses both
// reset clears the valid bits only; data registers are not reset
// a stalled valid result freezes the whole pipeline and in_stall_o follows
module quaternion_multiply_rotate_core #(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qmr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output qmr_pkg::out_t out_data_o
);

  localparam int unsigned D = qmr_pkg::HAM_DEPTH;

  logic           en;
  qmr_pkg::quat_t h1_p, h1_s, h1_r, h2_r;
  logic           h1_valid, h2_valid;

  qmr_pkg::quat_t p_dly_q  [D];
  logic           op_dly_q [D];
  qmr_pkg::quat_t t_dly_q  [D];
  logic           op2_dly_q [D];

  // global advance: stop only when a finished result is held back
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // first product operands; rotation takes the vector with scalar zero
  assign h1_p.x = in_data_i.p_x;
  assign h1_p.y = in_data_i.p_y;
  assign h1_p.z = in_data_i.p_z;
  assign h1_p.w = in_data_i.p_w;
  assign h1_s.x = in_data_i.s_x;
  assign h1_s.y = in_data_i.s_y;
  assign h1_s.z = in_data_i.s_z;
  assign h1_s.w = (in_data_i.opcode == qmr_pkg::OP_ROT) ? '0 : in_data_i.s_w;

  qmr_hamilton #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ham1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .conj_i  (1'b0),
    .p_i     (h1_p),
    .s_i     (h1_s),
    .valid_o (h1_valid),
    .r_o     (h1_r)
  );

  // p and opcode wait for the first product
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_dly_q[0]  <= h1_p;
      op_dly_q[0] <= in_data_i.opcode;
      for (int i = 1; i < D; i++) begin
        p_dly_q[i]  <= p_dly_q[i-1];
        op_dly_q[i] <= op_dly_q[i-1];
      end
    end
  end

  // second product t * conj(p), conjugate folded into the term signs
  qmr_hamilton #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ham2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h1_valid),
    .conj_i  (1'b1),
    .p_i     (h1_r),
    .s_i     (p_dly_q[D-1]),
    .valid_o (h2_valid),
    .r_o     (h2_r)
  );

  // first product and opcode ride alongside the second unit
  always_ff @(posedge clk_i) begin
    if (en) begin
      t_dly_q[0]   <= h1_r;
      op2_dly_q[0] <= op_dly_q[D-1];
      for (int i = 1; i < D; i++) begin
        t_dly_q[i]   <= t_dly_q[i-1];
        op2_dly_q[i] <= op2_dly_q[i-1];
      end
    end
  end

  // result select
  assign out_valid_o = h2_valid;
  always_comb begin
    if (op2_dly_q[D-1] == qmr_pkg::OP_ROT) begin
      out_data_o.r_x = h2_r.x;
      out_data_o.r_y = h2_r.y;
      out_data_o.r_z = h2_r.z;
      out_data_o.r_w = h2_r.w;
    end else begin
      out_data_o.r_x = t_dly_q[D-1].x;
      out_data_o.r_y = t_dly_q[D-1].y;
      out_data_o.r_z = t_dly_q[D-1].z;
      out_data_o.r_w = t_dly_q[D-1].w;
    end
  end

`ifndef ASSERT_OFF
  // the pipeline only holds input back while a result is waiting
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // a held result freezes the valid bits of both units
  a_freeze_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(h1_valid))
    else $error("first unit advanced during output stall");

  a_freeze_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("pending result lost during output stall");
`endif

endmodule
